// ===== sv/sorted_breakpoint_table_defines.svh =====
// Assertion macros shared by the breakpoint table modules.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SORTED_BREAKPOINT_TABLE_DEFINES_SVH
`define SORTED_BREAKPOINT_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sbt_pkg.sv =====
`timescale 1ns / 1ps

package sbt_pkg;

    // Field widths fixed by the interface.
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int SLOT_W = 6;

    // Default table depth; slot_index is six bits, so at most 64.
    localparam int SLOTS_DEF = 10;

    localparam logic [BYTE_W-1:0] TRAP_BYTE = 8'hFF;
    localparam logic [ADDR_W-1:0] FREE_ADDR = 16'hFFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_FIND = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // Contents of one table slot.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] sbyte;
        logic              used;
    } t_entry;

    // Search token that ripples down the cell chain.
    typedef struct packed {
        logic              fnd;
        logic              match;
        logic [SLOT_W-1:0] idx;
        logic [BYTE_W-1:0] sbyte;
    } t_token;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clr;
        logic scan;
        logic ins;
        logic del;
    } t_cmd;

endpackage

// ===== sv/sorted_breakpoint_table.sv =====
`timescale 1ns / 1ps

// Sorted software breakpoint table. A transaction is accepted when start is
// high and busy is low; busy then stays high and the single result appears on
// the o_ ports with o_valid high for exactly one cycle, registered from the
// commit state. Each transaction passes through the request latch, the scan,
// in which the search token moves one cell of the slot chain per cycle, and
// the commit of the table update; no new one is taken while busy is high. The
// receiver cannot stall the result: it must take o_valid when it comes. No
// clearing pass is needed after reset.
module sorted_breakpoint_table #(
    parameter int SLOTS = sbt_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sbt_pkg::REQ_W-1:0]  i_req_type,
    input  logic [sbt_pkg::ADDR_W-1:0] i_target_address,
    input  logic [sbt_pkg::BYTE_W-1:0] i_memory_byte,
    output logic                       o_valid,
    output logic [sbt_pkg::STAT_W-1:0] o_status,
    output logic                       o_write_enable,
    output logic [sbt_pkg::BYTE_W-1:0] o_write_byte,
    output logic                       o_hit,
    output logic [sbt_pkg::SLOT_W-1:0] o_slot_index
);
    import sbt_pkg::*;

    `include "sorted_breakpoint_table_defines.svh"

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_req              r_req;
    logic [ADDR_W-1:0] r_key;
    logic [BYTE_W-1:0] r_mbyte;

    t_cmd   w_cmd;
    t_entry w_state [SLOTS];
    logic   w_less  [SLOTS];
    t_token w_tok   [SLOTS];
    t_token w_res;
    logic   w_full;

    logic              n_valid;
    t_status           n_status;
    logic              n_we;
    logic [BYTE_W-1:0] n_wbyte;
    logic              n_hit;
    logic [SLOT_W-1:0] n_slot;

    assign busy   = (r_state != ST_IDLE);
    assign w_res  = w_tok[SLOTS-1];
    assign w_full = w_state[SLOTS-1].used;

    // Chain of slot cells, each talking only to its two neighbors.
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_lless;
        t_token w_tin;

        if (gi == 0) begin : g_head
            assign w_left  = '{addr: FREE_ADDR, sbyte: '0, used: 1'b0};
            assign w_lless = 1'b1;
            assign w_tin   = '0;
        end else begin : g_body
            assign w_left  = w_state[gi-1];
            assign w_lless = w_less[gi-1];
            assign w_tin   = w_tok[gi-1];
        end

        if (gi == SLOTS - 1) begin : g_tail
            assign w_right = '{addr: FREE_ADDR, sbyte: '0, used: 1'b0};
        end else begin : g_inner
            assign w_right = w_state[gi+1];
        end

        sbt_cell #(
            .CELL_IDX (SLOT_W'(gi))
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_key         (r_key),
            .i_mbyte       (r_mbyte),
            .i_left_state  (w_left),
            .i_right_state (w_right),
            .i_left_less   (w_lless),
            .i_tok         (w_tin),
            .o_state       (w_state[gi]),
            .o_less        (w_less[gi]),
            .o_tok         (w_tok[gi])
        );
    end

    // Next state of the sequencer. The count stops on the last scan cycle.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_W'(SLOTS - 1)) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_COMMIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands to the cells and the result of the transaction.
    always_comb begin
        w_cmd    = '0;
        n_valid  = 1'b0;
        n_status = STAT_OK;
        n_we     = 1'b0;
        n_wbyte  = '0;
        n_hit    = 1'b0;
        n_slot   = '0;
        case (r_state)
            ST_IDLE: begin
                w_cmd.clr = start;
            end
            ST_SCAN: begin
                w_cmd.scan = 1'b1;
            end
            ST_COMMIT: begin
                n_valid = 1'b1;
                case (r_req)
                    REQ_ADD: begin
                        if (w_res.fnd && w_res.match) begin
                            n_slot = w_res.idx;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_cmd.ins = 1'b1;
                            n_we      = 1'b1;
                            n_wbyte   = TRAP_BYTE;
                            n_slot    = w_res.idx;
                        end
                    end
                    REQ_DEL: begin
                        if (w_res.fnd && w_res.match) begin
                            w_cmd.del = 1'b1;
                            n_we      = 1'b1;
                            n_wbyte   = w_res.sbyte;
                            n_slot    = w_res.idx;
                        end else begin
                            n_status = STAT_NOT_FOUND;
                        end
                    end
                    REQ_FIND: begin
                        if (w_res.fnd && w_res.match) begin
                            n_hit  = 1'b1;
                            n_slot = w_res.idx;
                        end
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_valid <= n_valid;
        end
    end

    // Request capture and result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_req   <= t_req'(i_req_type);
            r_key   <= i_target_address;
            r_mbyte <= i_memory_byte;
        end
        if (n_valid) begin
            o_status       <= n_status;
            o_write_enable <= n_we;
            o_write_byte   <= n_wbyte;
            o_hit          <= n_hit;
            o_slot_index   <= n_slot;
        end
    end

    // The result strobe only follows a commit cycle.
    `SBT_ASSERT_SAME(a_valid_after_commit, o_valid, $past(r_state) == ST_COMMIT, "sbt: stray result strobe")
    // A memory write is only requested by a successful transaction.
    `SBT_ASSERT_SAME(a_write_ok, o_valid && o_write_enable, o_status == STAT_OK, "sbt: write on failure")
    // The commit only comes after the token has crossed every cell.
    `SBT_ASSERT_SAME(a_scan_done, r_state == ST_COMMIT, r_cnt == CNT_W'(SLOTS - 1), "sbt: short scan")
    // A find never asks for a memory write.
    `SBT_ASSERT_SAME(a_hit_no_write, o_valid && o_hit, !o_write_enable, "sbt: write on find")

endmodule

// ===== sv/sbt_cell.sv =====
`timescale 1ns / 1ps

module sbt_cell #(
    parameter logic [sbt_pkg::SLOT_W-1:0] CELL_IDX = '0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sbt_pkg::t_cmd              i_cmd,
    input  logic [sbt_pkg::ADDR_W-1:0] i_key,
    input  logic [sbt_pkg::BYTE_W-1:0] i_mbyte,
    input  sbt_pkg::t_entry            i_left_state,
    input  sbt_pkg::t_entry            i_right_state,
    input  logic                       i_left_less,
    input  sbt_pkg::t_token            i_tok,
    output sbt_pkg::t_entry            o_state,
    output logic                       o_less,
    output sbt_pkg::t_token            o_tok
);
    import sbt_pkg::*;

    `include "sorted_breakpoint_table_defines.svh"

    logic              r_used;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_sbyte;
    t_token            r_tok;

    logic              n_used;
    logic [ADDR_W-1:0] n_addr;
    logic [BYTE_W-1:0] n_sbyte;
    t_token            n_tok;

    logic   w_first;
    t_token w_local;

    // Local compare against the broadcast key. Active entries form a sorted
    // prefix, so the first cell that is not below the key is the insert point.
    assign o_less  = r_used && (r_addr < i_key);
    assign w_first = !o_less && i_left_less;
    assign o_state = '{addr: r_addr, sbyte: r_sbyte, used: r_used};

    always_comb begin
        w_local.fnd   = w_first;
        w_local.match = r_used && (r_addr == i_key);
        w_local.idx   = CELL_IDX;
        w_local.sbyte = r_sbyte;
    end

    // The token from the left wins once found; otherwise this cell offers its own.
    always_comb begin
        if (i_cmd.clr) begin
            n_tok = '0;
        end else if (i_cmd.scan) begin
            n_tok = i_tok.fnd ? i_tok : w_local;
        end else begin
            n_tok = r_tok;
        end
    end

    // Insert shifts the tail right by one slot; delete pulls it left by one.
    always_comb begin
        n_used  = r_used;
        n_addr  = r_addr;
        n_sbyte = r_sbyte;
        if (i_cmd.ins && !o_less) begin
            if (w_first) begin
                n_used  = 1'b1;
                n_addr  = i_key;
                n_sbyte = i_mbyte;
            end else begin
                n_used  = i_left_state.used;
                n_addr  = i_left_state.addr;
                n_sbyte = i_left_state.sbyte;
            end
        end else if (i_cmd.del && !o_less) begin
            n_used  = i_right_state.used;
            n_addr  = i_right_state.addr;
            n_sbyte = i_right_state.sbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_addr <= FREE_ADDR;
            r_tok  <= '0;
        end else begin
            r_used <= n_used;
            r_addr <= n_addr;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sbyte <= n_sbyte;
    end

    assign o_tok = r_tok;

    // Active entries stay a prefix of the chain, sorted strictly ascending.
    `SBT_ASSERT_SAME(a_used_prefix, !r_used, !i_right_state.used, "sbt_cell: free slot before used")
    `SBT_ASSERT_SAME(a_sorted, r_used && i_right_state.used, r_addr < i_right_state.addr, "sbt_cell: order broken")
    // An insert never frees a slot that was in use.
    `SBT_ASSERT_NEXT(a_ins_keeps, i_cmd.ins && r_used, r_used, "sbt_cell: insert lost an entry")

endmodule

// ===== dv/sorted_breakpoint_table_tb.sv =====
`timescale 1ns / 1ps

module sorted_breakpoint_table_tb;
    import sbt_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int IDLE_PCT   = 14;
    localparam int RAND_CMDS  = 1750;
    localparam int QUIET_LIMIT = 2000;

    // One debugger command as presented to the table.
    typedef struct packed {
        t_req              req;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mbyte;
    } t_bp_cmd;

    // One table response.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              we;
        logic [BYTE_W-1:0] wbyte;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_bp_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [REQ_W-1:0] i_req_type = '0;
    logic [ADDR_W-1:0] i_target_address = '0;
    logic [BYTE_W-1:0] i_memory_byte = '0;
    logic busy;
    logic o_valid;
    logic [STAT_W-1:0] o_status;
    logic o_write_enable;
    logic [BYTE_W-1:0] o_write_byte;
    logic o_hit;
    logic [SLOT_W-1:0] o_slot_index;

    // Commands waiting to be issued and responses still owed by the table.
    t_bp_cmd  cmd_q[$];
    t_bp_resp resp_q[$];
    t_bp_cmd  cur_cmd;
    t_bp_resp next_resp;
    t_bp_resp exp_resp;

    // Shadow copy of the breakpoint table.
    t_entry shadow_tbl[SLOTS];

    int n_sent = 0;
    int n_resp = 0;
    int n_errors = 0;
    int quiet_cycles = 0;
    int n_add_new = 0, n_add_dup = 0, n_add_full = 0;
    int n_del_ok = 0, n_del_miss = 0, n_find_hit = 0, n_find_miss = 0, n_ignored = 0;

    sorted_breakpoint_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_target_address (i_target_address),
        .i_memory_byte    (i_memory_byte),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_write_enable   (o_write_enable),
        .o_write_byte     (o_write_byte),
        .o_hit            (o_hit),
        .o_slot_index     (o_slot_index)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one command to the shadow table and returns the response it should give.
    task automatic apply_table_op(input t_bp_cmd c, output t_bp_resp r);
        int n;
        int pos;
        int found;
        int i;
        r = '0;
        r.status = STAT_OK;
        n = 0;
        found = SLOTS;
        for (i = 0; i < SLOTS; i++) begin
            if (shadow_tbl[i].used) begin
                n++;
                if (shadow_tbl[i].addr == c.addr && found == SLOTS)
                    found = i;
            end
        end
        case (c.req)
            REQ_ADD: begin
                if (found < SLOTS) begin
                    r.slot = SLOT_W'(found);
                    n_add_dup++;
                end else if (n >= SLOTS) begin
                    r.status = STAT_FULL;
                    n_add_full++;
                end else begin
                    pos = 0;
                    while (pos < n && shadow_tbl[pos].addr < c.addr)
                        pos++;
                    for (i = n; i > pos; i--)
                        shadow_tbl[i] = shadow_tbl[i-1];
                    shadow_tbl[pos].addr = c.addr;
                    shadow_tbl[pos].sbyte = c.mbyte;
                    shadow_tbl[pos].used = 1'b1;
                    r.we = 1'b1;
                    r.wbyte = TRAP_BYTE;
                    r.slot = SLOT_W'(pos);
                    n_add_new++;
                end
            end
            REQ_DEL: begin
                if (found >= SLOTS) begin
                    r.status = STAT_NOT_FOUND;
                    n_del_miss++;
                end else begin
                    r.we = 1'b1;
                    r.wbyte = shadow_tbl[found].sbyte;
                    r.slot = SLOT_W'(found);
                    for (i = found; i + 1 < SLOTS; i++)
                        shadow_tbl[i] = shadow_tbl[i+1];
                    shadow_tbl[SLOTS-1].addr = FREE_ADDR;
                    shadow_tbl[SLOTS-1].sbyte = '0;
                    shadow_tbl[SLOTS-1].used = 1'b0;
                    n_del_ok++;
                end
            end
            REQ_FIND: begin
                if (found < SLOTS) begin
                    r.hit = 1'b1;
                    r.slot = SLOT_W'(found);
                    n_find_hit++;
                end else begin
                    n_find_miss++;
                end
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic queue_cmd(input t_req req, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] mbyte);
        t_bp_cmd c;
        c.req = req;
        c.addr = addr;
        c.mbyte = mbyte;
        cmd_q.push_back(c);
    endtask

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ERROR %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            n_errors++;
        end
    endfunction

    // Driver: issues queued commands, holds each one until the table accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_table_op(cur_cmd, next_resp);
                resp_q.push_back(next_resp);
                n_sent++;
            end
            if (!(start && busy)) begin
                // A long stretch in the middle of the run goes without idle cycles.
                if (cmd_q.size() != 0 &&
                    ((n_sent >= 700 && n_sent < 1000) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_cmd = cmd_q.pop_front();
                    start <= 1'b1;
                    i_req_type <= cur_cmd.req;
                    i_target_address <= cur_cmd.addr;
                    i_memory_byte <= cur_cmd.mbyte;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed response is matched against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (resp_q.size() == 0) begin
                $display("%0t ERROR unexpected response: status %0d slot %0d",
                         $time, o_status, o_slot_index);
                n_errors++;
            end else begin
                exp_resp = resp_q.pop_front();
                check_field("status", exp_resp.status, o_status);
                check_field("write_enable", exp_resp.we, o_write_enable);
                check_field("write_byte", exp_resp.wbyte, o_write_byte);
                check_field("hit", exp_resp.hit, o_hit);
                check_field("slot_index", exp_resp.slot, o_slot_index);
                n_resp++;
            end
        end
    end

    // Watchdog: ends the run if neither a command nor a response moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t timeout with %0d responses outstanding", $time, resp_q.size());
                $display("sorted_breakpoint_table_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] pool[$];
        logic [ADDR_W-1:0] a;
        int pool_len;
        int burst_len;
        int add_pct;
        int del_pct;
        int roll;
        int k;

        for (k = 0; k < SLOTS; k++) begin
            shadow_tbl[k].addr = FREE_ADDR;
            shadow_tbl[k].sbyte = '0;
            shadow_tbl[k].used = 1'b0;
        end

        // Directed: empty table, extreme addresses, duplicates, full table, ends and middle.
        queue_cmd(REQ_FIND, 16'h1234, 8'h00);
        queue_cmd(REQ_DEL, 16'h1234, 8'hFF);
        queue_cmd(REQ_ADD, 16'hFFFF, 8'h00);
        queue_cmd(REQ_FIND, 16'hFFFF, 8'h00);
        queue_cmd(REQ_ADD, 16'h0000, 8'hFF);
        queue_cmd(REQ_ADD, 16'h8000, 8'hA5);
        queue_cmd(REQ_ADD, 16'h8000, 8'h11);
        queue_cmd(REQ_NONE, 16'hFFFF, 8'hFF);
        queue_cmd(REQ_ADD, 16'h0001, 8'h5A);
        queue_cmd(REQ_ADD, 16'h7FFF, 8'h01);
        queue_cmd(REQ_ADD, 16'h4000, 8'h80);
        queue_cmd(REQ_ADD, 16'h0100, 8'h7F);
        queue_cmd(REQ_ADD, 16'hFFFE, 8'hC3);
        queue_cmd(REQ_ADD, 16'h1234, 8'h3C);
        queue_cmd(REQ_ADD, 16'hC000, 8'h99);
        queue_cmd(REQ_ADD, 16'h5555, 8'h42);
        queue_cmd(REQ_ADD, 16'h0000, 8'h24);
        queue_cmd(REQ_FIND, 16'hFFFF, 8'h00);
        queue_cmd(REQ_DEL, 16'hFFFF, 8'h00);
        queue_cmd(REQ_DEL, 16'h0000, 8'h00);
        queue_cmd(REQ_DEL, 16'h8000, 8'h00);
        queue_cmd(REQ_DEL, 16'h8000, 8'h00);
        queue_cmd(REQ_FIND, 16'h4000, 8'h00);
        queue_cmd(REQ_NONE, 16'h0000, 8'h00);

        // Random bursts: each uses a small address pool so adds, deletes and finds
        // keep colliding, and the add/delete mix swings the table between empty and full.
        k = 0;
        while (k < RAND_CMDS) begin
            pool.delete();
            pool_len = $urandom_range(2, 18);
            repeat (pool_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    pool.push_back(16'h0000);
                else if (roll < 10)
                    pool.push_back(16'hFFFF);
                else
                    pool.push_back(ADDR_W'($urandom()));
            end
            burst_len = $urandom_range(20, 80);
            add_pct = $urandom_range(25, 60);
            del_pct = $urandom_range(15, 40);
            repeat (burst_len) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    a = ADDR_W'($urandom());
                else
                    a = pool[$urandom_range(0, pool_len - 1)];
                if (roll < 3)
                    queue_cmd(REQ_NONE, a, BYTE_W'($urandom()));
                else if (roll < 3 + add_pct)
                    queue_cmd(REQ_ADD, a, BYTE_W'($urandom()));
                else if (roll < 3 + add_pct + del_pct)
                    queue_cmd(REQ_DEL, a, BYTE_W'($urandom()));
                else
                    queue_cmd(REQ_FIND, a, BYTE_W'($urandom()));
                k++;
            end
        end

        // Hold synchronous reset, then release it.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all commands issued and every response received, then a short tail.
        @(negedge i_clk);
        while (cmd_q.size() != 0 || start || resp_q.size() != 0)
            @(negedge i_clk);
        repeat (SLOTS + 4) @(negedge i_clk);

        $display("Ran %0d commands, checked %0d responses: adds %0d new, %0d repeat, %0d full.",
                 n_sent, n_resp, n_add_new, n_add_dup, n_add_full);
        $display("Deletes %0d removed, %0d absent; finds %0d hit, %0d miss; %0d unknown.",
                 n_del_ok, n_del_miss, n_find_hit, n_find_miss, n_ignored);
        if (n_errors == 0) begin
            $display("sorted_breakpoint_table_tb: PASS");
        end else begin
            $display("sorted_breakpoint_table_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sorted_breakpoint_table.f =====
+incdir+sv
sv/sbt_pkg.sv
sv/sbt_cell.sv
sv/sorted_breakpoint_table.sv
dv/sorted_breakpoint_table_tb.sv
